@@ sv/tdcl_pkg.sv @@
package tdcl_pkg;

  // Register indexes on the configuration port (byte address = 4 * index)
  localparam int CfgAddrWidth = 4;
  localparam logic [1:0] REG_KEY_RGB     = 2'd0;
  localparam logic [1:0] REG_KEY_ALPHA   = 2'd1;
  localparam logic [1:0] REG_TRANS_ALPHA = 2'd2;

  // One pixel transaction
  typedef struct packed {
    logic [23:0] pixel_rgb;
    logic [7:0]  pixel_alpha;
  } pixel_t;

  // One per-tile result transaction
  typedef struct packed {
    logic        violation;
    logic [2:0]  bad_row;
    logic [2:0]  bad_col;
    logic [23:0] bad_rgb;
    logic [7:0]  bad_alpha;
    logic [4:0]  distinct_count;
  } result_t;

  // Palette store control from the tile logic
  typedef struct packed {
    logic add;
    logic clear;
  } palette_ctrl_t;

  // Palette store status back to the tile logic
  typedef struct packed {
    logic hit;
    logic full;
  } palette_stat_t;

endpackage

@@ sv/tile_distinct_color_limit_check.sv @@
// A tile's result goes from the input register into the result register once that register is free.
// One pixel per cycle, except while the final pixel of a tile waits for the result register;
// one result per TILE_SIDE*TILE_SIDE pixels.
// Reset (rst, synchronous): clears configuration, tile position, palette fill,
// failure record and both valid flags; palette entry contents are not cleared.
module tile_distinct_color_limit_check
  import tdcl_pkg::*;
#(
  parameter int PALETTE_SIZE = 16,
  parameter int TILE_SIDE = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  // pixel channel
  input  logic                    pixel_valid,
  output logic                    pixel_stall,
  input  pixel_t                  pixel,
  // result channel
  output logic                    result_valid,
  input  logic                    result_stall,
  output result_t                 result,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int FW = (PALETTE_SIZE > 2) ? $clog2(PALETTE_SIZE) : 1;
  localparam int PW = (TILE_SIDE > 2) ? $clog2(TILE_SIDE) : 1;

  // Configuration registers
  logic [23:0] key_rgb;
  logic [7:0]  key_alpha;
  logic [7:0]  transparent_alpha;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_rgb           <= '0;
      key_alpha         <= '0;
      transparent_alpha <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_KEY_RGB:     key_rgb           <= pwdata[23:0];
        REG_KEY_ALPHA:   key_alpha         <= pwdata[7:0];
        REG_TRANS_ALPHA: transparent_alpha <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_KEY_RGB:     prdata = {8'd0, key_rgb};
      REG_KEY_ALPHA:   prdata = {24'd0, key_alpha};
      REG_TRANS_ALPHA: prdata = {24'd0, transparent_alpha};
      default:         prdata = '0;
    endcase
  end

  // Input register
  logic   in_valid;
  pixel_t in_pixel;
  logic   advance;
  logic   out_free;
  logic   accept;

  assign out_free    = !result_valid || !result_stall;
  assign pixel_stall = in_valid && !advance;
  assign accept      = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_pixel <= pixel;
    end
  end

  // Tile state
  logic [PW-1:0] row;
  logic [PW-1:0] col;
  logic          tile_failed;
  logic [2:0]    fail_row;
  logic [2:0]    fail_col;
  logic [23:0]   fail_rgb;
  logic [7:0]    fail_alpha;

  logic          last;
  logic          counted;
  logic          consider;
  logic          fail_now;
  logic          failed_next;
  logic [2:0]    row_rec;
  logic [2:0]    col_rec;
  logic [23:0]   rgb_rec;
  logic [7:0]    alpha_rec;
  logic [FW:0]   count_next;

  palette_ctrl_t pal_ctrl;
  palette_stat_t pal_stat;
  logic [FW-1:0] pal_fill;

  tdcl_palette #(
    .PALETTE_SIZE(PALETTE_SIZE),
    .FW(FW)
  ) u_palette (
    .clk   (clk),
    .rst   (rst),
    .color ({in_pixel.pixel_alpha, in_pixel.pixel_rgb}),
    .ctrl  (pal_ctrl),
    .stat  (pal_stat),
    .fill  (pal_fill)
  );

  assign last = (row == PW'(TILE_SIDE - 1)) && (col == PW'(TILE_SIDE - 1));
  // The final pixel of a tile waits until the result register is free
  assign advance = in_valid && (!last || out_free);

  // Pixel classification and palette decision
  always_comb begin
    counted  = (in_pixel.pixel_alpha != transparent_alpha) &&
               !((in_pixel.pixel_rgb == key_rgb) && (in_pixel.pixel_alpha == key_alpha));
    consider = !tile_failed && counted && !pal_stat.hit;
    fail_now = consider && pal_stat.full;

    pal_ctrl.add   = advance && consider && !pal_stat.full;
    pal_ctrl.clear = advance && last;

    failed_next = tile_failed || fail_now;
    row_rec     = fail_now ? 3'(row) : fail_row;
    col_rec     = fail_now ? 3'(col) : fail_col;
    rgb_rec     = fail_now ? in_pixel.pixel_rgb : fail_rgb;
    alpha_rec   = fail_now ? in_pixel.pixel_alpha : fail_alpha;

    count_next  = {1'b0, pal_fill} + (FW+1)'(pal_ctrl.add);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row         <= '0;
      col         <= '0;
      tile_failed <= 1'b0;
      fail_row    <= '0;
      fail_col    <= '0;
      fail_rgb    <= '0;
      fail_alpha  <= '0;
    end else if (advance) begin
      if (last) begin
        row         <= '0;
        col         <= '0;
        tile_failed <= 1'b0;
        fail_row    <= '0;
        fail_col    <= '0;
        fail_rgb    <= '0;
        fail_alpha  <= '0;
      end else begin
        if (col == PW'(TILE_SIDE - 1)) begin
          col <= '0;
          row <= row + PW'(1);
        end else begin
          col <= col + PW'(1);
        end
        tile_failed <= failed_next;
        fail_row    <= row_rec;
        fail_col    <= col_rec;
        fail_rgb    <= rgb_rec;
        fail_alpha  <= alpha_rec;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last) begin
      result.violation      <= failed_next;
      result.bad_row        <= row_rec;
      result.bad_col        <= col_rec;
      result.bad_rgb        <= rgb_rec;
      result.bad_alpha      <= alpha_rec;
      result.distinct_count <= failed_next ? 5'(PALETTE_SIZE) : 5'(count_next);
    end
  end

endmodule

@@ sv/tdcl_palette.sv @@
module tdcl_palette
  import tdcl_pkg::*;
#(
  parameter int PALETTE_SIZE = 16,
  parameter int FW = (PALETTE_SIZE > 2) ? $clog2(PALETTE_SIZE) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   color,
  input  palette_ctrl_t ctrl,
  output palette_stat_t stat,
  output logic [FW-1:0] fill
);

  localparam int Depth = PALETTE_SIZE - 1;
  localparam int IW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [31:0] store [Depth];
  logic [FW-1:0] fill_next;

  // Parallel compare against the valid entries
  always_comb begin
    stat.hit = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      if ((FW'(i) < fill) && (store[i] == color)) begin
        stat.hit = 1'b1;
      end
    end
    stat.full = (fill == FW'(Depth));
  end

  always_comb begin
    fill_next = fill;
    if (ctrl.clear) begin
      fill_next = '0;
    end else if (ctrl.add) begin
      fill_next = fill + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // Entry write; contents need no reset since reads are gated by the fill count
  always_ff @(posedge clk) begin
    if (ctrl.add && !stat.full) begin
      store[fill[IW-1:0]] <= color;
    end
  end

endmodule

@@ tb/sv/tile_distinct_color_limit_check_tb.sv @@
`timescale 1ns / 100ps

module tile_distinct_color_limit_check_tb;
  import tdcl_pkg::*;

  localparam int PaletteSize = 16;
  localparam int TileSide = 8;
  localparam int TilePixels = TileSide * TileSide;
  localparam int StoreDepth = PaletteSize - 1;
  localparam int PhaseTiles = 3;
  localparam int RandomPhases = 7;

  // Tracks the palette of the current tile and holds the per-tile results still due
  class tile_palette_scoreboard;
    logic [23:0] key_rgb;
    logic [7:0]  key_alpha;
    logic [7:0]  trans_alpha;
    logic [31:0] seen [StoreDepth];
    int          fill;
    int          pos;
    bit          failed;
    logic [2:0]  fail_row;
    logic [2:0]  fail_col;
    logic [23:0] fail_rgb;
    logic [7:0]  fail_alpha;
    result_t     due_tiles [$];
    int          mismatches;
    int          tiles_checked;

    function new();
      key_rgb = '0;
      key_alpha = '0;
      trans_alpha = '0;
      mismatches = 0;
      tiles_checked = 0;
      clear_tile();
    endfunction

    function void clear_tile();
      fill = 0;
      pos = 0;
      failed = 1'b0;
      fail_row = '0;
      fail_col = '0;
      fail_rgb = '0;
      fail_alpha = '0;
    endfunction

    // Accepted pixel: update the tile palette, queue a result on the tile's last pixel
    function void note_pixel(pixel_t p);
      logic [31:0] colour;
      bit          counted;
      bit          found;
      result_t     r;
      colour = {p.pixel_alpha, p.pixel_rgb};
      counted = (p.pixel_alpha != trans_alpha) &&
                !(p.pixel_rgb == key_rgb && p.pixel_alpha == key_alpha);
      if (!failed && counted) begin
        found = 1'b0;
        for (int i = 0; i < fill; i++) begin
          if (seen[i] == colour) found = 1'b1;
        end
        if (!found) begin
          if (fill < StoreDepth) begin
            seen[fill] = colour;
            fill++;
          end else begin
            failed = 1'b1;
            fail_row = 3'(pos / TileSide);
            fail_col = 3'(pos % TileSide);
            fail_rgb = p.pixel_rgb;
            fail_alpha = p.pixel_alpha;
          end
        end
      end
      if (pos + 1 >= TilePixels) begin
        r.violation = failed;
        r.bad_row = fail_row;
        r.bad_col = fail_col;
        r.bad_rgb = fail_rgb;
        r.bad_alpha = fail_alpha;
        r.distinct_count = failed ? 5'(PaletteSize) : 5'(fill);
        due_tiles.push_back(r);
        clear_tile();
      end else begin
        pos++;
      end
    endfunction

    task report(string msg);
      $display("tile %0d: %s", tiles_checked, msg);
      mismatches++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Accepted result: compare against the oldest tile still due
    task check_result(result_t r);
      result_t want;
      if (due_tiles.size() == 0) begin
        report($sformatf("result 0x%0h with no tile outstanding", r));
      end else begin
        want = due_tiles.pop_front();
        check_field("violation", 32'(r.violation), 32'(want.violation));
        check_field("bad_row", 32'(r.bad_row), 32'(want.bad_row));
        check_field("bad_col", 32'(r.bad_col), 32'(want.bad_col));
        check_field("bad_rgb", 32'(r.bad_rgb), 32'(want.bad_rgb));
        check_field("bad_alpha", 32'(r.bad_alpha), 32'(want.bad_alpha));
        check_field("distinct_count", 32'(r.distinct_count), 32'(want.distinct_count));
      end
      tiles_checked++;
    endtask
  endclass

  logic                    clk;
  logic                    rst;
  logic                    pixel_valid;
  logic                    pixel_stall;
  pixel_t                  pixel;
  logic                    result_valid;
  logic                    result_stall;
  result_t                 result;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CfgAddrWidth-1:0] paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  tile_palette_scoreboard sb = new();
  pixel_t tile_buf [TilePixels];
  bit     tx_steady;
  bit     rx_steady;

  tile_distinct_color_limit_check #(
    .PALETTE_SIZE(PaletteSize),
    .TILE_SIDE(TileSide)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel(pixel),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // One pixel transaction, preceded by a random gap unless tx_steady is set; returns at a falling edge
  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel <= p;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (pixel_stall);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  task automatic send_tile();
    if ($urandom_range(0, 5) == 0) tx_steady = ~tx_steady;
    for (int i = 0; i < TilePixels; i++) send_pixel(tile_buf[i]);
  endtask

  // Hold off the sender until every tile result is back, then let the pipe settle
  task automatic drain();
    pixel_valid <= 1'b0;
    while (sb.due_tiles.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_KEY_RGB:     sb.key_rgb = val[23:0];
      REG_KEY_ALPHA:   sb.key_alpha = val[7:0];
      REG_TRANS_ALPHA: sb.trans_alpha = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [23:0] krgb, input logic [7:0] ka,
                            input logic [7:0] ta);
    drain();
    write_reg(REG_KEY_RGB, {8'h00, krgb});
    write_reg(REG_KEY_ALPHA, {24'h0, ka});
    write_reg(REG_TRANS_ALPHA, {24'h0, ta});
  endtask

  // Random tile: mostly drawn from a small pool of colours, with transparent,
  // key and noise pixels mixed in; an occasional tile is pure noise
  task automatic fill_random_tile();
    pixel_t pool [32];
    int     k;
    int     r;
    bit     noise;
    k = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 17);
    noise = ($urandom_range(0, 15) == 0);
    for (int j = 0; j < k; j++) begin
      pool[j] = $urandom;
      if ($urandom_range(0, 9) == 0) pool[j].pixel_rgb = sb.key_rgb;
    end
    for (int i = 0; i < TilePixels; i++) begin
      r = $urandom_range(0, 99);
      if (noise || r < 4) begin
        tile_buf[i] = $urandom;
      end else if (r < 12) begin
        tile_buf[i].pixel_rgb = 24'($urandom);
        tile_buf[i].pixel_alpha = sb.trans_alpha;
      end else if (r < 18) begin
        tile_buf[i] = {sb.key_rgb, sb.key_alpha};
      end else begin
        tile_buf[i] = pool[$urandom_range(0, k - 1)];
      end
    end
  endtask

  function automatic logic [31:0] pick_value(input logic [31:0] max_val);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return max_val;
      default: return $urandom & max_val;
    endcase
  endfunction

  // Result side: stall randomly before accepting each result, except in steady stretches
  initial begin
    int n;
    result_stall = 1'b0;
    rx_steady = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) rx_steady = ~rx_steady;
      n = rx_steady ? 0 : $urandom_range(0, 3);
      if (n > 0) begin
        result_stall <= 1'b1;
        do @(posedge clk); while (!result_valid);
        repeat (n) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      sb.check_result(result);
      @(negedge clk);
    end
  end

  // Main sequence
  initial begin
    rst = 1'b1;
    pixel_valid = 1'b0;
    pixel = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_steady = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset config: key and transparent alpha both zero
    // fully transparent tile, count 0
    for (int i = 0; i < TilePixels; i++)
      tile_buf[i] = {(i % 2) ? 24'hFFFFFF : 24'(i), 8'h00};
    send_tile();
    // exactly fills the palette store, no violation
    for (int i = 0; i < TilePixels; i++)
      tile_buf[i] = {24'hFFFFFF - 24'(i % 15), 8'hFF - 8'(i % 15)};
    send_tile();
    // overflow on the very last pixel
    for (int i = 0; i < TilePixels; i++)
      tile_buf[i] = {24'hFFFFFF - 24'((i < 15) ? i : 0), 8'hFF - 8'((i < 15) ? i : 0)};
    tile_buf[TilePixels - 1] = {24'h000001, 8'h01};
    send_tile();
    // every pixel new: overflow mid-tile, later new colours ignored
    for (int i = 0; i < TilePixels; i++)
      tile_buf[i] = {24'(i * 24'h010203), 8'(i + 1)};
    send_tile();

    // Extreme config: key is all ones, transparent alpha all ones
    set_config(24'hFFFFFF, 8'hFF, 8'hFF);
    for (int i = 0; i < TilePixels; i++) begin
      case (i % 4)
        0: tile_buf[i] = {24'hFFFFFF, 8'hFF};
        1: tile_buf[i] = {24'h000000, 8'hFF};
        2: tile_buf[i] = {24'hFFFFFF, 8'hFE};
        default: tile_buf[i] = {24'h000000, 8'h00};
      endcase
    end
    send_tile();

    // Key colour vs near misses on either half of it
    set_config(24'hA5A5A5, 8'h5A, 8'h7F);
    for (int i = 0; i < TilePixels; i++) begin
      case (i % 5)
        0: tile_buf[i] = {24'hA5A5A5, 8'h5A};
        1: tile_buf[i] = {24'hA5A5A5, 8'h5B};
        2: tile_buf[i] = {24'hA5A5A4, 8'h5A};
        3: tile_buf[i] = {24'(i), 8'h7F};
        default: tile_buf[i] = {24'h5A5A5A, 8'hA5};
      endcase
    end
    send_tile();

    // Random phases, each with its own config
    for (int ph = 0; ph < RandomPhases; ph++) begin
      if (ph == 0)
        set_config(24'h0, 8'h0, 8'h0);
      else if (ph == RandomPhases - 1)
        set_config(24'hFFFFFF, 8'hFF, 8'hFF);
      else
        set_config(24'(pick_value(32'hFFFFFF)), 8'(pick_value(32'hFF)),
                   8'(pick_value(32'hFF)));
      for (int t = 0; t < PhaseTiles; t++) begin
        fill_random_tile();
        send_tile();
        if ($urandom_range(0, 5) == 0) drain();
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (sb.due_tiles.size() != 0)
      sb.report($sformatf("%0d tile results never arrived", sb.due_tiles.size()));
    if (sb.mismatches == 0)
      $display("** tile_distinct_color_limit_check: PASSED **");
    else
      $display("** tile_distinct_color_limit_check: FAILED **");
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("** tile_distinct_color_limit_check: FAILED **");
    $finish;
  end

endmodule
